// ===== rtl/sorted_priority_queue_top_assert.svh =====
// Assertion macros for the sorted priority queue checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;
    localparam int OCC_W   = 5;

    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } spq_cmd_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } spq_status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } spq_entry_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic       enq;
        logic       deq;
        spq_entry_t item;
    } spq_ctrl_t;

endpackage

// ===== rtl/sorted_priority_queue_top.sv =====
// Sorted priority queue: a chain of CAPACITY cells, head in cell 0.
// The result word is registered when an input word is accepted.
// Throughput: 1 word per cycle while the result side takes each result; every cell compares and shifts in parallel.
// Reset (rst_n, async, active low): queue empty, no result pending.
// Cell contents are not reset; the entry count marks which cells hold data.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      command,
    input  logic signed [VALUE_W-1:0] item_value,
    input  logic [PRIO_W-1:0]         item_priority,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                status,
    output logic signed [VALUE_W-1:0] out_value,
    output logic [PRIO_W-1:0]         out_priority,
    output logic [OCC_W-1:0]          occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Entry count: cells [0, count) hold valid words in sorted order
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Output stage
    logic                     out_valid_reg;
    logic                     out_valid_next;
    spq_status_t              status_reg;
    spq_status_t              status_next;
    logic [VALUE_W-1:0]       out_value_reg;
    logic [VALUE_W-1:0]       out_value_next;
    logic [PRIO_W-1:0]        out_priority_reg;
    logic [PRIO_W-1:0]        out_priority_next;
    logic [OCC_W-1:0]         occupancy_reg;
    logic [OCC_W-1:0]         occupancy_next;
    logic [CNT_W+OCC_W-1:0]   occ_ext;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    logic       is_deq;
    spq_ctrl_t  ctrl;

    spq_entry_t cell_entry [CAPACITY];
    logic       cell_ins   [CAPACITY];

    // Accept a new word whenever the output stage is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign is_deq   = (spq_cmd_t'(command) == CMD_DEQUEUE);

    // Drop enqueue when full; ignore dequeue when empty
    assign ctrl.enq        = accept && !is_deq && !is_full;
    assign ctrl.deq        = accept && is_deq && !is_empty;
    assign ctrl.item.value = $unsigned(item_value);
    assign ctrl.item.prio  = item_priority;

    // Cell chain: each cell sees its neighbors and the broadcast control
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_entry_t left_entry;
        spq_entry_t right_entry;
        logic       left_ins;
        logic       occupied;

        assign occupied = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            // Head has no left neighbor: a new word inserted here is always the new one
            assign left_ins   = 1'b0;
            assign left_entry = ctrl.item;
        end
        else
        begin : g_body
            assign left_ins   = cell_ins[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            // Tail falls out of range on dequeue; contents do not matter
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (occupied),
            .left_ins    (left_ins),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .ins         (cell_ins[i]),
            .entry       (cell_entry[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Occupancy reports the count masked to the field width
    assign occ_ext = {{OCC_W{1'b0}}, count_next};

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        out_value_next    = out_value_reg;
        out_priority_next = out_priority_reg;
        occupancy_next    = occupancy_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next    = 1'b1;
            out_value_next    = '0;
            out_priority_next = '0;
            occupancy_next    = occ_ext[OCC_W-1:0];
            if (is_deq)
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    // Head leaves from cell 0
                    status_next       = ST_DEQUEUED;
                    out_value_next    = cell_entry[0].value;
                    out_priority_next = cell_entry[0].prio;
                end
            end
            else
            begin
                status_next = is_full ? ST_FULL : ST_ENQUEUED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload holds until the next accepted word
    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        out_value_reg    <= out_value_next;
        out_priority_reg <= out_priority_next;
        occupancy_reg    <= occupancy_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_value    = $signed(out_value_reg);
    assign out_priority = out_priority_reg;
    assign occupancy    = occupancy_reg;

endmodule

// ===== rtl/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  spq_ctrl_t  ctrl,
    input  logic       occupied,
    input  logic       left_ins,
    input  spq_entry_t left_entry,
    input  spq_entry_t right_entry,
    output logic       ins,
    output spq_entry_t entry
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // Take the new word here or further down: slot empty or strictly lower priority
    assign ins = !occupied || (entry_reg.prio < ctrl.item.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq && ins)
        begin
            // Left neighbor also moves down: shift its word in, else take the new one
            entry_next = left_ins ? left_entry : ctrl.item;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/spq_checker.sv =====
`include "sorted_priority_queue_top_assert.svh"

module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [1:0]                status,
    input logic signed [VALUE_W-1:0] out_value,
    input logic [PRIO_W-1:0]         out_priority,
    input logic [OCC_W-1:0]          occupancy
);

    localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);

    // Stalled result holds its status
    `SPQ_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(status), "result dropped or changed while stalled")

    // Empty dequeue leaves nothing behind and returns zeros
    `SPQ_ASSERT_IMPL(a_empty_zero, out_valid && status == ST_EMPTY, occupancy == '0 && out_value == '0 && out_priority == '0, "empty status with nonzero fields")

    // Full status only when the queue holds CAPACITY entries
    `SPQ_ASSERT_IMPL(a_full_count, out_valid && status == ST_FULL, occupancy == CAP_OCC && out_value == '0, "full status with wrong occupancy")

    // Successful enqueue leaves at least one entry and returns no data
    `SPQ_ASSERT_IMPL(a_enq_fields, out_valid && status == ST_ENQUEUED, occupancy != '0 && out_value == '0 && out_priority == '0, "enqueue result malformed")

endmodule

bind sorted_priority_queue_top spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

// ===== test/sorted_priority_queue_top_tb.sv =====
module sorted_priority_queue_top_tb
    import spq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH   = 16;
    localparam int RESET_CYCLES  = 4;
    // Cycles to keep watching after the last expected word, to catch any stray
    // late result; the block registers its answer when it accepts a word.
    localparam int SETTLE_CYCLES = 8;
    // About 1100 words at worst-case stalls stay far below this bound.
    localparam int CYCLE_LIMIT   = 400000;

    // One result word as the queue should report it.
    typedef struct packed {
        spq_status_t        status;
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
        logic [OCC_W-1:0]   occ;
    } queue_result_t;

    // Drive every block input to a known value from time zero.
    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      in_valid      = 1'b0;
    logic                      in_ready;
    logic                      command       = 1'b0;
    logic signed [VALUE_W-1:0] item_value    = '0;
    logic [PRIO_W-1:0]         item_priority = '0;
    logic                      out_valid;
    logic                      out_ready     = 1'b0;
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] out_value;
    logic [PRIO_W-1:0]         out_priority;
    logic [OCC_W-1:0]          occupancy;

    // Sorted contents of the queue as predicted, head at index 0.
    logic [VALUE_W-1:0] held_values[$];
    logic [PRIO_W-1:0]  held_prios[$];
    // Results predicted for accepted words, oldest first.
    queue_result_t      pending_results[$];

    // Idle odds in percent per cycle; set before the directed tests and by each random phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned stored_count   = 0;
    int unsigned served_count   = 0;
    int unsigned empty_count    = 0;
    int unsigned dropped_count  = 0;

    sorted_priority_queue_top #(
        .CAPACITY(QUEUE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .item_value   (item_value),
        .item_priority(item_priority),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_value    (out_value),
        .out_priority (out_priority),
        .occupancy    (occupancy)
    );

    always #10 clk = ~clk;

    // Apply one accepted word to the predicted queue and return its result.
    // An entry goes in front of the first held entry of strictly lower
    // priority, so equal priorities keep arrival order.
    function automatic queue_result_t apply_queue_word(spq_cmd_t cmd,
                                                       logic [VALUE_W-1:0] val,
                                                       logic [PRIO_W-1:0] pr);
        queue_result_t r;
        int            pos;
        r.status = ST_ENQUEUED;
        r.value  = '0;
        r.prio   = '0;
        if (cmd == CMD_ENQUEUE) begin
            if (held_prios.size() >= QUEUE_DEPTH) begin
                // Drop the entry; the queue stays as it is.
                r.status = ST_FULL;
            end
            else begin
                pos = held_prios.size();
                for (int i = held_prios.size() - 1; i >= 0; i--)
                    if (held_prios[i] < pr)
                        pos = i;
                held_values.insert(pos, val);
                held_prios.insert(pos, pr);
            end
        end
        else if (held_prios.size() == 0) begin
            r.status = ST_EMPTY;
        end
        else begin
            r.status = ST_DEQUEUED;
            r.value  = held_values.pop_front();
            r.prio   = held_prios.pop_front();
        end
        r.occ = OCC_W'(held_prios.size());
        return r;
    endfunction

    // Stall the result side at random, at the current phase's odds.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Check each result word against the oldest expectation, then predict
    // the word accepted at this edge. A result never shares an edge with its
    // own word, so checking first is safe.
    always @(posedge clk)
    begin : result_monitor
        queue_result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing expected: status %0d", status);
                    mismatch_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatch_count++;
                    end
                    if (out_value !== want.value) begin
                        $error("out_value: expected %0d, actual %0d",
                               $signed(want.value), out_value);
                        mismatch_count++;
                    end
                    if (out_priority !== want.prio) begin
                        $error("out_priority: expected %0d, actual %0d",
                               want.prio, out_priority);
                        mismatch_count++;
                    end
                    if (occupancy !== want.occ) begin
                        $error("occupancy: expected %0d, actual %0d", want.occ, occupancy);
                        mismatch_count++;
                    end
                    case (want.status)
                        ST_ENQUEUED: stored_count++;
                        ST_DEQUEUED: served_count++;
                        ST_EMPTY:    empty_count++;
                        default:     dropped_count++;
                    endcase
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(apply_queue_word(spq_cmd_t'(command),
                                                           item_value, item_priority));
        end
    end

    // Abort a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one word and hold it until accepted. Insert a random gap first;
    // leave valid high afterwards so back-to-back words never lower it.
    task automatic send_word(input spq_cmd_t cmd, input logic [VALUE_W-1:0] val,
                             input logic [PRIO_W-1:0] pr);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        item_value    <= val;
        item_priority <= pr;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop sending until every predicted result has come back, then let the
    // block settle.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Favor the extremes and the all-ones and all-zeros patterns.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mix a few coarse levels (many ties) with the edges and the full range.
    function automatic logic [PRIO_W-1:0] pick_priority();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return 8'($urandom_range(3) * 85);
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic reset_block();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    // Dequeue from the empty queue right after reset.
    task automatic test_empty_dequeue();
        send_word(CMD_DEQUEUE, 32'h1234_5678, 8'h5A);
    endtask

    // Extreme entries and a run of equal priorities that must leave in order.
    task automatic test_priority_order();
        send_word(CMD_ENQUEUE, 32'h7FFF_FFFF, 8'hFF);
        send_word(CMD_ENQUEUE, 32'h8000_0000, 8'h00);
        send_word(CMD_ENQUEUE, 32'h0000_0000, 8'h80);
        send_word(CMD_ENQUEUE, 32'hFFFF_FFFF, 8'h80);
        send_word(CMD_ENQUEUE, 32'h0000_0001, 8'h80);
        send_word(CMD_DEQUEUE, 32'hFFFF_FFFF, 8'hFF);
        send_word(CMD_DEQUEUE, 32'h0000_0000, 8'h00);
    endtask

    // Three entries remain; top the queue up, push one more at the highest
    // priority (it must be dropped), then take two off the head.
    task automatic test_fill_and_overflow();
        for (int i = 0; i < QUEUE_DEPTH - 3; i++)
            send_word(CMD_ENQUEUE, 32'hA5A5_0000 | i, (i % 3 == 0) ? 8'hFF : 8'(i * 19));
        send_word(CMD_ENQUEUE, 32'h5A5A_5A5A, 8'hFF);
        send_word(CMD_DEQUEUE, 32'h0, 8'h0);
        send_word(CMD_DEQUEUE, 32'h0, 8'h0);
    endtask

    // Random traffic in bursts. Each burst draws its own enqueue odds, mostly
    // leaning toward enqueue or dequeue, so the queue swings between empty and
    // full; now and then pause until all results are in.
    task automatic test_random_traffic(input int unsigned word_total,
                                       input int unsigned send_pct,
                                       input int unsigned recv_pct);
        int unsigned sent;
        int unsigned burst_len;
        int unsigned enq_pct;
        spq_cmd_t    cmd;
        sent          = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent < word_total) begin
            burst_len = $urandom_range(40, 4);
            case ($urandom_range(4))
                0:       enq_pct = 15;
                1:       enq_pct = 40;
                2:       enq_pct = 50;
                3:       enq_pct = 60;
                default: enq_pct = 85;
            endcase
            for (int unsigned k = 0; k < burst_len && sent < word_total; k++) begin
                cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
                send_word(cmd, pick_value(), pick_priority());
                sent++;
            end
            if ($urandom_range(19) == 0)
                hold_until_drained();
        end
        hold_until_drained();
    endtask

    initial begin
        send_idle_pct = 32;
        recv_idle_pct = 58;
        reset_block();
        test_empty_dequeue();
        test_priority_order();
        test_fill_and_overflow();
        hold_until_drained();
        test_random_traffic(370, 32, 58);
        test_random_traffic(370, 58, 32);
        test_random_traffic(360, 0, 0);
        hold_until_drained();

        $display("Ran directed empty, order and overflow cases, then three random phases");
        $display("  (%0d stored, %0d served, %0d empty dequeues, %0d dropped when full).",
                 stored_count, served_count, empty_count, dropped_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sorted_priority_queue_top.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
rtl/spq_checker.sv
test/sorted_priority_queue_top_tb.sv
